>>> hdl/ktis_pkg.sv
// Shared definitions for the key/tag insertion sorter.
// Holds the default sizes, the order mode codes and the controller/datapath structs.
// No dependencies.
package ktis_pkg;

    // default sizes
    localparam int unsigned MAX_ITEMS_DEF = 64;
    localparam int unsigned KEY_BITS_DEF  = 32;
    localparam int unsigned TAG_BITS_DEF  = 16;

    // order mode codes
    localparam logic [1:0] MODE_LT = 2'd0;
    localparam logic [1:0] MODE_LE = 2'd1;
    localparam logic [1:0] MODE_GT = 2'd2;
    localparam logic [1:0] MODE_GE = 2'd3;

    // controller -> datapath commands
    typedef struct packed {
        logic latch_item;   // capture incoming beat, start position at fill count
        logic drop;         // store full, mark batch as overflowed
        logic launch_rd;    // read entry just below insert position
        logic step;         // move entry up one slot, read next one down
        logic place;        // write new item at insert position, bump fill
        logic emit_rd;      // read entry at output index
        logic emit_next;    // advance output index
        logic clear;        // end of run, empty the store
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic full;         // fill count at capacity
        logic in_last;      // incoming beat ends the batch
        logic item_last;    // latched item ends the batch
        logic precedes;     // new key must pass the stored key just read
        logic out_last;     // output index is on the final stored entry
    } t_sts;

endpackage

>>> hdl/key_tag_insertion_sorter_core.sv
// Key/tag insertion sorter, top level.
// Usage:
//   Slave stream s_axis: one beat per item, tdata = {tag, key}, tlast marks the
//   last item of a batch. Each item is inserted into a sorted store as it arrives.
//   Master stream m_axis: on the batch end the store is read out in order, one
//   beat per stored item; tlast marks the final beat, tuser flags a batch that
//   lost items beyond capacity (MAX_ITEMS).
//   Config channel i_cfg_*: order mode, 0 less (stable ascending), 1 less-or-equal,
//   2 greater (stable descending), 3 greater-or-equal. Ready only while idle.
// Sequencing:
//   An item is latched, the entry just below its insert position is read, and the
//   item then moves past each stored entry it must pass, one memory read and one
//   write per step, before it is placed; an item dropped on a full store is only
//   latched, with no insertion. Readout reads the memory, then offers the output
//   beat, for each result; a stall holds the beat and no new item is taken until the run is out.
//   After the last item is placed or dropped, the first result is read, then offered.
// Reset: synchronous, active low; empties the store and sets the mode to 0.
// Depends on ktis_pkg, ktis_ctrl, ktis_datapath.
module key_tag_insertion_sorter_core
    import ktis_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int unsigned KEY_BITS  = KEY_BITS_DEF,
    parameter int unsigned TAG_BITS  = TAG_BITS_DEF,
    localparam int unsigned DW       = ((KEY_BITS + TAG_BITS + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config write channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_data,    // order_mode
    // input items
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [DW-1:0] s_axis_tdata,  // sort_key, item_tag, zero pad
    input  logic          s_axis_tlast,  // batch_end
    // sorted results
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [DW-1:0] m_axis_tdata,  // sorted_key, sorted_tag, zero pad
    output logic          m_axis_tlast,  // run_end
    output logic [0:0]    m_axis_tuser   // overflowed
);

    t_cmd                cmd;
    t_sts                sts;
    logic [KEY_BITS-1:0] out_key;
    logic [TAG_BITS-1:0] out_tag;
    logic                out_run_end;
    logic                out_ovf;

    // mode writes only between items, never under an insertion or readout
    assign o_cfg_ready = s_axis_tready;

    ktis_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    ktis_datapath #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (i_cfg_valid & o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_key        (s_axis_tdata[KEY_BITS-1:0]),
        .i_tag        (s_axis_tdata[KEY_BITS+TAG_BITS-1:KEY_BITS]),
        .i_last       (s_axis_tlast),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_key        (out_key),
        .o_tag        (out_tag),
        .o_run_end    (out_run_end),
        .o_overflowed (out_ovf)
    );

    // result beat packing
    assign m_axis_tdata = DW'({out_tag, out_key});
    assign m_axis_tlast = out_run_end;
    assign m_axis_tuser = out_ovf;

endmodule

>>> hdl/ktis_ctrl.sv
// Controller state machine for the key/tag insertion sorter.
// Sequences load, insertion shifts and the sorted readout; drives the stream handshakes.
// Depends on ktis_pkg.
module ktis_ctrl
    import ktis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LAUNCH = 3'd1;
    localparam logic [2:0] ST_INS    = 3'd2;
    localparam logic [2:0] ST_EMIT_R = 3'd3;
    localparam logic [2:0] ST_EMIT_O = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT_O);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.latch_item = 1'b1;
                    if (i_sts.full) begin
                        o_cmd.drop = 1'b1;
                        n_state    = i_sts.in_last ? ST_EMIT_R : ST_IDLE;
                    end else begin
                        n_state = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH: begin
                o_cmd.launch_rd = 1'b1;
                n_state         = ST_INS;
            end
            ST_INS: begin
                if (i_sts.precedes) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = i_sts.item_last ? ST_EMIT_R : ST_IDLE;
                end
            end
            ST_EMIT_R: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = ST_EMIT_O;
            end
            ST_EMIT_O: begin
                if (m_axis_tready) begin
                    if (i_sts.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                        n_state         = ST_EMIT_R;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ktis_datapath.sv
// Datapath for the key/tag insertion sorter: sorted store memory, comparator,
// fill count, overflow flag, insert position and output index, order mode register.
// Depends on ktis_pkg.
module ktis_datapath
    import ktis_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int unsigned KEY_BITS  = KEY_BITS_DEF,
    parameter int unsigned TAG_BITS  = TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr,
    input  logic [1:0]          i_cfg_data,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [TAG_BITS-1:0] i_tag,
    input  logic                i_last,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [KEY_BITS-1:0] o_key,
    output logic [TAG_BITS-1:0] o_tag,
    output logic                o_run_end,
    output logic                o_overflowed
);

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned MW = KEY_BITS + TAG_BITS;

    logic [MW-1:0]       r_mem [MAX_ITEMS];
    logic [MW-1:0]       r_rd;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_last;
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       r_k;
    logic [CW-1:0]       r_fill;
    logic                r_dropped;
    logic [1:0]          r_mode;

    logic [AW-1:0]       rd_addr;
    logic                rd_en;
    logic                wr_en;
    logic [MW-1:0]       wr_data;
    logic [KEY_BITS-1:0] rd_key;
    logic                key_lt;
    logic                key_eq;
    logic                cmp;

    // order mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LT;
        end else if (i_cfg_wr) begin
            r_mode <= i_cfg_data;
        end
    end

    // latched item
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_key  <= i_key;
            r_tag  <= i_tag;
            r_last <= i_last;
        end
    end

    // insert position: starts at fill count, walks down one slot per shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_pos <= r_fill[AW-1:0];
        end else if (i_cmd.step) begin
            r_pos <= r_pos - AW'(1);
        end
    end

    // fill count, overflow flag, output index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_dropped <= 1'b0;
            r_k       <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_fill    <= '0;
                r_dropped <= 1'b0;
                r_k       <= '0;
            end else begin
                if (i_cmd.place) begin
                    r_fill <= r_fill + CW'(1);
                end
                if (i_cmd.drop) begin
                    r_dropped <= 1'b1;
                end
                if (i_cmd.emit_next) begin
                    r_k <= r_k + AW'(1);
                end
            end
        end
    end

    // memory ports
    always_comb begin
        priority if (i_cmd.emit_rd) begin
            rd_addr = r_k;
        end else if (i_cmd.launch_rd) begin
            rd_addr = r_pos - AW'(1);
        end else begin
            rd_addr = r_pos - AW'(2);
        end
    end
    assign rd_en   = i_cmd.emit_rd | i_cmd.launch_rd | i_cmd.step;
    assign wr_en   = i_cmd.step | i_cmd.place;
    assign wr_data = i_cmd.step ? r_rd : {r_tag, r_key};

    // sorted store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // comparator of new key against stored key
    assign rd_key = r_rd[KEY_BITS-1:0];
    assign key_lt = $signed(r_key) < $signed(rd_key);
    assign key_eq = (r_key == rd_key);
    always_comb begin
        unique case (r_mode)
            MODE_LT: cmp = key_lt;
            MODE_LE: cmp = key_lt | key_eq;
            MODE_GT: cmp = ~key_lt & ~key_eq;
            MODE_GE: cmp = ~key_lt;
            default: cmp = key_lt;
        endcase
    end

    // status to controller
    assign o_sts.full      = (r_fill == CW'(MAX_ITEMS));
    assign o_sts.in_last   = i_last;
    assign o_sts.item_last = r_last;
    assign o_sts.precedes  = (r_pos != '0) & cmp;
    assign o_sts.out_last  = (CW'(r_k) == (r_fill - CW'(1)));

    // result payload, held while the beat waits
    assign o_key        = r_rd[KEY_BITS-1:0];
    assign o_tag        = r_rd[MW-1:KEY_BITS];
    assign o_run_end    = o_sts.out_last;
    assign o_overflowed = r_dropped;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_ITEMS))
        else $error("fill count beyond capacity");
    a_step_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_pos != '0))
        else $error("shift below bottom of store");
    a_place_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.place |-> (r_fill < CW'(MAX_ITEMS)))
        else $error("item placed into full store");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_fill == '0) && !r_dropped && (r_k == '0))
        else $error("store not emptied after run");
`endif

endmodule

>>> test/key_tag_insertion_sorter_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for key_tag_insertion_sorter_core: streams item batches,
// predicts each sorted run in all four order modes and checks every result beat.
// Depends on ktis_pkg and the sorter RTL.
module key_tag_insertion_sorter_core_tb;
    import ktis_pkg::*;

    localparam int unsigned MAX_ITEMS   = MAX_ITEMS_DEF;
    localparam int unsigned KEY_BITS    = KEY_BITS_DEF;
    localparam int unsigned TAG_BITS    = TAG_BITS_DEF;
    localparam int unsigned DW          = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int          SETTLE_CYC  = MAX_ITEMS + 8;   // worst insert time plus margin
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          SHOW_MAX    = 10;

    typedef logic signed [KEY_BITS-1:0] t_key;
    typedef logic [TAG_BITS-1:0]        t_tag;

    // one expected or observed result beat
    typedef struct packed {
        t_key key;
        t_tag tag;
        logic run_end;
        logic overflowed;
    } t_sorted_beat;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata;   // sort_key, item_tag, zero pad
    logic          s_axis_tlast;   // batch_end
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [DW-1:0] m_axis_tdata;   // sorted_key, sorted_tag, zero pad
    logic          m_axis_tlast;   // run_end
    logic [0:0]    m_axis_tuser;   // overflowed

    key_tag_insertion_sorter_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow copy of the sorted store
    t_key         shadow_keys [MAX_ITEMS];
    t_tag         shadow_tags [MAX_ITEMS];
    int           shadow_fill;
    bit           shadow_dropped;
    logic [1:0]   shadow_mode;
    t_sorted_beat sorted_expect_q [$];

    int           mismatch_cnt;
    int           cycle_cnt;
    bit           idle_en;
    int           stall_left;
    t_sorted_beat got_beat;
    t_sorted_beat want_beat;

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // comparator chosen by the order mode
    function automatic bit key_precedes(t_key a, t_key b);
        case (shadow_mode)
            MODE_LT: return a < b;
            MODE_LE: return a <= b;
            MODE_GT: return a > b;
            default: return a >= b;
        endcase
    endfunction

    // insert one accepted item, queue the sorted run when it closes the batch
    function automatic void insert_and_predict(t_key key, t_tag tag, bit batch_end);
        int           pos;
        t_sorted_beat beat;
        if (shadow_fill >= MAX_ITEMS) begin
            shadow_dropped = 1'b1;
        end else begin
            pos = shadow_fill;
            while (pos > 0 && key_precedes(key, shadow_keys[pos-1])) begin
                shadow_keys[pos] = shadow_keys[pos-1];
                shadow_tags[pos] = shadow_tags[pos-1];
                pos--;
            end
            shadow_keys[pos] = key;
            shadow_tags[pos] = tag;
            shadow_fill++;
        end
        if (batch_end) begin
            for (int k = 0; k < shadow_fill; k++) begin
                beat.key        = shadow_keys[k];
                beat.tag        = shadow_tags[k];
                beat.run_end    = (k == shadow_fill - 1);
                beat.overflowed = shadow_dropped;
                sorted_expect_q.push_back(beat);
            end
            shadow_fill    = 0;
            shadow_dropped = 1'b0;
        end
    endfunction

    // key mix: full range, narrow range with many ties, or the extremes
    function automatic t_key pick_key(int flavor);
        int unsigned sel;
        case (flavor)
            0: return t_key'($urandom);
            1: return t_key'(int'($urandom_range(0, 8)) - 4);
            default: begin
                sel = $urandom_range(0, 5);
                case (sel)
                    0: return {1'b1, {(KEY_BITS-1){1'b0}}};
                    1: return {1'b0, {(KEY_BITS-1){1'b1}}};
                    2: return {1'b1, {(KEY_BITS-2){1'b0}}, 1'b1};
                    3: return {1'b0, {(KEY_BITS-2){1'b1}}, 1'b0};
                    4: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    // send one item beat; entered and left on a falling edge
    task automatic send_item(t_key key, t_tag tag, bit batch_end);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, key};
        s_axis_tlast  <= batch_end;
        do @(posedge i_clk); while (!s_axis_tready);
        insert_and_predict(key, tag, batch_end);
        @(negedge i_clk);
    endtask

    // stop sending, wait for all results, then let the block settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sorted_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // write the order mode while the block is idle
    task automatic set_order_mode(logic [1:0] mode);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_mode = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one batch of random items
    task automatic send_batch(int size, int flavor);
        for (int i = 0; i < size; i++)
            send_item(pick_key(flavor), t_tag'($urandom_range(0, 65535)), i == size - 1);
    endtask

    // extremes, ties and a one-item batch in the reset mode, then a tie batch in every mode
    task automatic test_directed();
        send_item({1'b0, {(KEY_BITS-1){1'b1}}}, 16'hFFFF, 1'b0);
        send_item({1'b1, {(KEY_BITS-1){1'b0}}}, 16'h0000, 1'b0);
        send_item(t_key'(0),  16'h0001, 1'b0);
        send_item(t_key'(-1), 16'h0002, 1'b0);
        send_item(t_key'(5),  16'h0003, 1'b0);
        send_item(t_key'(5),  16'h0004, 1'b0);
        send_item(t_key'(1),  16'h0005, 1'b1);
        send_item(t_key'(42), 16'hA5A5, 1'b1);
        for (int m = 0; m < 4; m++) begin
            set_order_mode(2'(m));
            send_item(t_key'(7),  t_tag'(16 * m + 1), 1'b0);
            send_item(t_key'(-7), t_tag'(16 * m + 2), 1'b0);
            send_item(t_key'(7),  t_tag'(16 * m + 3), 1'b0);
            send_item(t_key'(7),  t_tag'(16 * m + 4), 1'b1);
        end
    endtask

    // full store, dropped item closing a batch, dropped items inside a batch
    task automatic test_capacity();
        set_order_mode(MODE_LT);
        send_batch(MAX_ITEMS, 0);
        set_order_mode(MODE_GE);
        send_batch(MAX_ITEMS + 1, 1);
        set_order_mode(MODE_LE);
        for (int i = 0; i < MAX_ITEMS + 3; i++)
            send_item(t_key'(-i), t_tag'(i), i == MAX_ITEMS + 2);
    endtask

    // random batches in every mode, with idling on both sides except in the greater-or-equal phase
    task automatic test_random();
        int          sent;
        int          size;
        logic [1:0]  modes [4];
        modes = '{MODE_GT, MODE_LT, MODE_GE, MODE_LE};
        for (int ph = 0; ph < 4; ph++) begin
            set_order_mode(modes[ph]);
            idle_en = (ph != 2);
            sent    = 0;
            while (sent < 12) begin
                size = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 70)
                                                    : $urandom_range(1, 10);
                send_batch(size, $urandom_range(0, 2));
                sent += size;
                if (ph == 1 && sent >= 6 && sent - size < 6)
                    wait_drained();
            end
        end
    endtask

    // closing stretch without idling
    task automatic test_quiet_tail();
        idle_en = 1'b0;
        set_order_mode(2'($urandom_range(0, 3)));
        for (int b = 0; b < 6; b++)
            send_batch($urandom_range(1, 8), $urandom_range(0, 2));
    endtask

    // receiver stalls in bursts that start at random while idling is enabled
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // check every result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_beat.key        = m_axis_tdata[KEY_BITS-1:0];
            got_beat.tag        = m_axis_tdata[KEY_BITS +: TAG_BITS];
            got_beat.run_end    = m_axis_tlast;
            got_beat.overflowed = m_axis_tuser[0];
            if (sorted_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOW_MAX)
                    $display("unexpected result beat: key=%0d tag=%h last=%b ovf=%b",
                             got_beat.key, got_beat.tag, got_beat.run_end,
                             got_beat.overflowed);
            end else begin
                want_beat = sorted_expect_q.pop_front();
                if (got_beat !== want_beat) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= SHOW_MAX) begin
                        $write("result mismatch: expected key=%0d tag=%h last=%b ovf=%b,",
                               want_beat.key, want_beat.tag, want_beat.run_end,
                               want_beat.overflowed);
                        $display(" actual key=%0d tag=%h last=%b ovf=%b",
                                 got_beat.key, got_beat.tag, got_beat.run_end,
                                 got_beat.overflowed);
                    end
                end
            end
        end
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        shadow_fill    = 0;
        shadow_dropped = 1'b0;
        shadow_mode    = MODE_LT;
        mismatch_cnt   = 0;
        cycle_cnt      = 0;
        stall_left     = 0;
        idle_en        = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_capacity();
        test_random();
        test_quiet_tail();
        wait_drained();

        if (sorted_expect_q.size() != 0) begin
            mismatch_cnt += sorted_expect_q.size();
            $display("%0d expected result beats never arrived", sorted_expect_q.size());
        end
        if (mismatch_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/ktis_pkg.sv
hdl/ktis_ctrl.sv
hdl/ktis_datapath.sv
hdl/key_tag_insertion_sorter_core.sv
test/key_tag_insertion_sorter_core_tb.sv
